// ===== design/gpio_port_register_block_unit_assert.svh =====
// ----------------------------------------------------------------------------
// GPIO port register block assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GPIO_PORT_REGISTER_BLOCK_UNIT_ASSERT_SVH
`define GPIO_PORT_REGISTER_BLOCK_UNIT_ASSERT_SVH

// same-cycle implication
`define GPR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GPR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gpr_pkg.sv =====
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types and constants of the GPIO port register block.
// ----------------------------------------------------------------------------
package gpr_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_PIN   = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_MODE  = 3'd0,
        REG_LEVEL = 3'd1,
        REG_REDIR = 3'd2,
        REG_INDIS = 3'd3,
        REG_GRP0  = 3'd4,
        REG_GRP1  = 3'd5
    } t_region;

    // decoded access kind
    typedef enum logic [3:0] {
        K_NONE,
        K_ERR,
        K_MODE,
        K_LEVEL,
        K_PIN,
        K_SIDE,
        K_REDIR,
        K_INDIS,
        K_DRIVE,
        K_CCS,
        K_CCDE,
        K_PFOE_LO,
        K_PFOE_HI
    } t_kind;

    // per-port side register arrays
    typedef enum logic [2:0] {
        SIDE_PU     = 3'd0,
        SIDE_PIM    = 3'd1,
        SIDE_POM    = 3'd2,
        SIDE_PMCA   = 3'd3,
        SIDE_PMCT   = 3'd4,
        SIDE_PMCE   = 3'd5,
        SIDE_PDIDIS = 3'd6
    } t_side_sel;

    localparam int unsigned SIDE_COUNT = 7;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // group1 sub-blocks (offset bits 6:4)
    localparam logic [2:0] GRP1_PMCT   = 3'd0;
    localparam logic [2:0] GRP1_PMCE   = 3'd2;
    localparam logic [2:0] GRP1_MISC   = 3'd4;
    localparam logic [2:0] GRP1_PDIDIS = 3'd5;
    localparam logic [2:0] GRP0_LAST   = 3'd3;

    // misc block register indexes (offset bits 3:0)
    localparam logic [3:0] MISC_DRV0    = 4'h0;
    localparam logic [3:0] MISC_DRV4    = 4'h4;
    localparam logic [3:0] MISC_DRV7    = 4'h7;
    localparam logic [3:0] MISC_CCS     = 4'h8;
    localparam logic [3:0] MISC_CCDE    = 4'h9;
    localparam logic [3:0] MISC_PFOE_LO = 4'hA;
    localparam logic [3:0] MISC_PFOE_HI = 4'hB;

    // special ports
    localparam logic [3:0] PORT_FIX_A   = 4'd10;
    localparam logic [3:0] PORT_FIX_B   = 4'd15;
    localparam logic [3:0] PORT_FIX_C   = 4'd12;
    localparam logic [3:0] PORT_GAP     = 4'd13;
    localparam logic [3:0] PORT_PU_INIT = 4'd4;

    // masks
    localparam logic [7:0] MASK_B7      = 8'h80;
    localparam logic [7:0] MASK_P12_FIX = 8'h18;
    localparam logic [7:0] MASK_P13_RSV = 8'h7E;
    localparam logic [7:0] MASK_TOP2    = 8'hC0;
    localparam logic [7:0] MASK_INDIS   = 8'hFE;
    localparam logic [7:0] DRIVE_MAX    = 8'h03;
    localparam logic [1:0] DRIVE_HIZ    = 2'd0;

    localparam logic [7:0] MODE_RESET  = 8'hFF;
    localparam logic [7:0] LEVEL_RESET = 8'h00;

    typedef struct packed {
        logic       we;
        t_kind      kind;
        logic [2:0] idx;
        logic [7:0] wdata;
    } t_misc_cmd;

    // reset contents of the side arrays
    function automatic logic [7:0] side_reset(t_side_sel sel, logic is_pu_port);
        logic [7:0] val;
        val = 8'h00;
        case (sel)
            SIDE_PMCA: val = 8'hFF;
            SIDE_PU:   val = is_pu_port ? 8'h01 : 8'h00;
            default:   val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ===== design/gpr_port_mem.sv =====
// ----------------------------------------------------------------------------
// gpr_port_mem
// Mode/level memory, one {mode, level} entry per port, registered read.
// ----------------------------------------------------------------------------
module gpr_port_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    output logic [15:0]   o_rdata
);
    import gpr_pkg::*;

    logic [15:0]      mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [15:0]      r_data;
    logic             r_data_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_data     <= mem[i_raddr];
            r_data_vld <= r_valid[i_raddr];
        end
    end

    // unwritten entries read as reset contents
    assign o_rdata = r_data_vld ? r_data : {MODE_RESET, LEVEL_RESET};

endmodule

// ===== design/gpr_side_mem.sv =====
// ----------------------------------------------------------------------------
// gpr_side_mem
// Side register memory (pull-up, PIM, POM, PMC*, PDIDIS), addressed by
// {array, port}, registered read.
// ----------------------------------------------------------------------------
module gpr_side_mem #(
    parameter int unsigned PW = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_re,
    input  gpr_pkg::t_side_sel  i_rsel,
    input  logic [PW-1:0]       i_rport,
    input  logic                i_we,
    input  gpr_pkg::t_side_sel  i_wsel,
    input  logic [PW-1:0]       i_wport,
    input  logic [7:0]          i_wdata,
    output logic [7:0]          o_rdata
);
    import gpr_pkg::*;

    localparam int unsigned DEPTH = SIDE_COUNT << PW;
    localparam int unsigned AW    = PW + 3;

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_data;
    logic [7:0]       r_rst_val;
    logic             r_data_vld;
    logic [AW-1:0]    raddr;
    logic [AW-1:0]    waddr;

    assign raddr = {i_rsel, i_rport};
    assign waddr = {i_wsel, i_wport};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[waddr] <= i_wdata;
        end
        if (i_re) begin
            r_data     <= mem[raddr];
            r_data_vld <= r_valid[raddr];
            r_rst_val  <= side_reset(i_rsel, i_rport == PW'(PORT_PU_INIT));
        end
    end

    assign o_rdata = r_data_vld ? r_data : r_rst_val;

endmodule

// ===== design/gpr_misc_regs.sv =====
// ----------------------------------------------------------------------------
// gpr_misc_regs
// Single registers: redirection, input disable, drive current, CCS, CCDE,
// PFOE. Applies masks on writes; an out-of-range drive value writes DRIVE_HIZ.
// ----------------------------------------------------------------------------
module gpr_misc_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gpr_pkg::t_misc_cmd i_cmd,
    output logic [7:0]         o_rdata,
    output logic               o_err
);
    import gpr_pkg::*;

    logic [1:0]  r_drive [8];
    logic [7:0]  r_ccs;
    logic [6:0]  r_ccde;
    logic [15:0] r_pfoe;
    logic [5:0]  r_redir;
    logic        r_indis;

    logic        drv_bad;

    assign drv_bad = i_cmd.wdata > DRIVE_MAX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_drive[i] <= DRIVE_HIZ;
            end
            r_ccs   <= '0;
            r_ccde  <= '0;
            r_pfoe  <= '0;
            r_redir <= '0;
            r_indis <= 1'b0;
        end else if (i_cmd.we) begin
            case (i_cmd.kind)
                K_REDIR:   r_redir <= i_cmd.wdata[5:0];
                K_INDIS:   r_indis <= i_cmd.wdata[0];
                K_DRIVE:   r_drive[i_cmd.idx] <= drv_bad ? DRIVE_HIZ : i_cmd.wdata[1:0];
                K_CCS:     r_ccs <= i_cmd.wdata;
                K_CCDE:    r_ccde <= i_cmd.wdata[6:0];
                K_PFOE_LO: r_pfoe[7:0] <= i_cmd.wdata;
                K_PFOE_HI: r_pfoe[15:8] <= i_cmd.wdata | MASK_TOP2;
                default:   ;
            endcase
        end
    end

    always_comb begin
        o_rdata = '0;
        o_err   = 1'b0;
        unique case (i_cmd.kind)
            K_REDIR: begin
                o_rdata = {2'b00, r_redir};
                o_err   = i_cmd.we && ((i_cmd.wdata & MASK_TOP2) != 8'h00);
            end
            K_INDIS: begin
                o_rdata = {7'b0, r_indis};
                o_err   = i_cmd.we && ((i_cmd.wdata & MASK_INDIS) != 8'h00);
            end
            K_DRIVE: begin
                o_rdata = {6'b0, r_drive[i_cmd.idx]};
                o_err   = i_cmd.we && drv_bad;
            end
            K_CCS:     o_rdata = r_ccs;
            K_CCDE: begin
                o_rdata = {1'b0, r_ccde};
                o_err   = i_cmd.we && i_cmd.wdata[7];
            end
            K_PFOE_LO: o_rdata = r_pfoe[7:0];
            K_PFOE_HI: begin
                o_rdata = r_pfoe[15:8];
                o_err   = i_cmd.we && ((i_cmd.wdata & MASK_TOP2) != MASK_TOP2);
            end
            default: begin
                o_rdata = '0;
                o_err   = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/gpio_port_register_block_unit.sv =====
// ----------------------------------------------------------------------------
// gpio_port_register_block_unit
// Byte-wide GPIO register block for 16 ports of 8 pins.
// ----------------------------------------------------------------------------
// Usage:
//   A command (bus read, bus write or pin event) is transferred at a rising
//   edge with start high and busy low. Its fields are sampled at that edge.
//   busy is high in the EXEC state entered at the transfer, while the
//   addressed memory entry is read, modified and written back.
//   In the cycle after EXEC the result shows on o_rdata, o_changed_mask,
//   o_port_levels and o_guest_error for a single cycle, marked by o_valid.
//   A new command is taken only while busy is low, as the registered read
//   of the port and side memories lies in front of the write-back.
//   Reset (synchronous, i_rst_n low) returns the FSM, o_valid, the misc
//   registers and every memory entry to reset contents at once, the
//   memories through per-entry valid bits; no clearing pass is needed.
//   The receiver takes each result in its strobe cycle and cannot stall
//   the block.
// ----------------------------------------------------------------------------
module gpio_port_register_block_unit #(
    parameter int unsigned PORT_COUNT = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_op,
    input  logic [2:0] i_region,
    input  logic [6:0] i_offset,
    input  logic [7:0] i_wdata,
    input  logic [3:0] i_pin_port,
    input  logic [2:0] i_pin_bit,
    input  logic       i_pin_level,
    output logic       o_valid,
    output logic [7:0] o_rdata,
    output logic [7:0] o_changed_mask,
    output logic [7:0] o_port_levels,
    output logic       o_guest_error
);
    import gpr_pkg::*;

    localparam int unsigned PW = $clog2(PORT_COUNT);

    t_state        r_state;
    t_state        n_state;
    logic          accept;
    logic          exec;

    // decoded command
    t_kind         n_kind;
    t_side_sel     n_sel;
    logic [PW-1:0] n_port;
    logic [2:0]    grp;
    logic [3:0]    idx;

    t_kind         r_kind;
    t_side_sel     r_sel;
    logic [PW-1:0] r_port;
    logic          r_wr;
    logic [7:0]    r_wdata;
    logic [2:0]    r_pbit;
    logic          r_plev;

    // memory side
    logic [15:0]   pm_rdata;
    logic          pm_we;
    logic [15:0]   pm_wdata;
    logic [7:0]    mode_q;
    logic [7:0]    level_q;
    logic [7:0]    side_q;
    logic          sd_we;

    t_misc_cmd     misc_cmd;
    logic [7:0]    misc_rdata;
    logic          misc_err;

    logic [7:0]    x_rdata;
    logic [7:0]    x_chg;
    logic [7:0]    x_lev;
    logic          x_err;

    assign accept = start && !busy;

    // ---------------- control FSM ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy = 1'b0;
        exec = 1'b0;
        unique case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_EXEC: begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    // ---------------- address decode ----------------
    assign grp = i_offset[6:4];
    assign idx = i_offset[3:0];

    always_comb begin
        n_kind = K_ERR;
        n_sel  = SIDE_PU;
        n_port = i_offset[PW-1:0];
        if (t_op'(i_op) == OP_PIN) begin
            n_kind = K_PIN;
            n_port = i_pin_port[PW-1:0];
        end else if (t_op'(i_op) == OP_NOP) begin
            n_kind = K_NONE;
        end else begin
            unique case (t_region'(i_region))
                REG_MODE: begin
                    if (i_offset < 7'(PORT_COUNT) && i_offset != 7'(PORT_GAP)) begin
                        n_kind = K_MODE;
                    end
                end
                REG_LEVEL: begin
                    if (i_offset < 7'(PORT_COUNT)) begin
                        n_kind = K_LEVEL;
                    end
                end
                REG_REDIR: if (i_offset == 7'd0) n_kind = K_REDIR;
                REG_INDIS: if (i_offset == 7'd0) n_kind = K_INDIS;
                REG_GRP0: begin
                    if (grp <= GRP0_LAST) begin
                        n_kind = K_SIDE;
                        n_sel  = t_side_sel'(grp);
                    end
                end
                REG_GRP1: begin
                    unique case (grp)
                        GRP1_PMCT: begin
                            n_kind = K_SIDE;
                            n_sel  = SIDE_PMCT;
                        end
                        GRP1_PMCE: begin
                            n_kind = K_SIDE;
                            n_sel  = SIDE_PMCE;
                        end
                        GRP1_PDIDIS: begin
                            n_kind = K_SIDE;
                            n_sel  = SIDE_PDIDIS;
                        end
                        GRP1_MISC: begin
                            unique case (idx) inside
                                MISC_DRV0, [MISC_DRV4:MISC_DRV7]: n_kind = K_DRIVE;
                                MISC_CCS:     n_kind = K_CCS;
                                MISC_CCDE:    n_kind = K_CCDE;
                                MISC_PFOE_LO: n_kind = K_PFOE_LO;
                                MISC_PFOE_HI: n_kind = K_PFOE_HI;
                                default:      n_kind = K_ERR;
                            endcase
                        end
                        default: n_kind = K_ERR;
                    endcase
                end
                default: n_kind = K_ERR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= n_kind;
            r_sel   <= n_sel;
            r_port  <= n_port;
            r_wr    <= t_op'(i_op) == OP_WRITE;
            r_wdata <= i_wdata;
            r_pbit  <= i_pin_bit;
            r_plev  <= i_pin_level;
        end
    end

    // ---------------- storage ----------------
    gpr_port_mem #(
        .DEPTH (PORT_COUNT),
        .AW    (PW)
    ) u_port_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (accept),
        .i_raddr (n_port),
        .i_we    (pm_we),
        .i_waddr (r_port),
        .i_wdata (pm_wdata),
        .o_rdata (pm_rdata)
    );

    assign mode_q  = pm_rdata[15:8];
    assign level_q = pm_rdata[7:0];

    gpr_side_mem #(
        .PW (PW)
    ) u_side_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (accept),
        .i_rsel  (n_sel),
        .i_rport (n_port),
        .i_we    (sd_we),
        .i_wsel  (r_sel),
        .i_wport (r_port),
        .i_wdata (r_wdata),
        .o_rdata (side_q)
    );

    assign misc_cmd.we    = exec && r_wr;
    assign misc_cmd.kind  = r_kind;
    assign misc_cmd.idx   = r_port[2:0];
    assign misc_cmd.wdata = r_wdata;

    gpr_misc_regs u_misc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (misc_cmd),
        .o_rdata (misc_rdata),
        .o_err   (misc_err)
    );

    // ---------------- read-modify-write ----------------
    always_comb begin
        logic [7:0] force_m;
        logic [7:0] rsv_m;
        logic [7:0] dval;
        logic [7:0] nv;
        logic [7:0] plev_v;

        force_m  = '0;
        rsv_m    = '0;
        dval     = '0;
        nv       = '0;
        plev_v   = level_q;
        pm_we    = 1'b0;
        pm_wdata = pm_rdata;
        sd_we    = 1'b0;
        x_rdata  = '0;
        x_chg    = '0;
        x_lev    = '0;
        x_err    = 1'b0;

        case (r_kind)
            K_MODE: begin
                if (r_port == PW'(PORT_FIX_A) || r_port == PW'(PORT_FIX_B)) begin
                    force_m = MASK_B7;
                end else if (r_port == PW'(PORT_FIX_C)) begin
                    force_m = MASK_P12_FIX;
                end
                if (r_wr) begin
                    x_err    = (r_wdata & force_m) != force_m;
                    pm_we    = exec;
                    pm_wdata = {r_wdata | force_m, level_q};
                end else begin
                    x_rdata = mode_q;
                end
            end
            K_LEVEL: begin
                if (r_port == PW'(PORT_FIX_A) || r_port == PW'(PORT_FIX_B)) begin
                    rsv_m = MASK_B7;
                end else if (r_port == PW'(PORT_GAP)) begin
                    rsv_m = MASK_P13_RSV;
                end
                if (r_wr) begin
                    x_err    = (r_wdata & rsv_m) != 8'h00;
                    dval     = r_wdata & ~rsv_m;
                    // only output pins (mode bit 0) take the written value
                    nv       = (level_q & mode_q) | (~mode_q & dval);
                    pm_we    = exec;
                    pm_wdata = {mode_q, nv};
                    x_chg    = level_q ^ nv;
                    x_lev    = nv;
                end else begin
                    x_rdata = level_q;
                end
            end
            K_PIN: begin
                if (mode_q[r_pbit]) begin
                    plev_v[r_pbit] = r_plev;
                    pm_we    = exec;
                    pm_wdata = {mode_q, plev_v};
                end else begin
                    x_err = 1'b1;
                end
            end
            K_SIDE: begin
                if (r_wr) begin
                    sd_we = exec;
                end else begin
                    x_rdata = side_q;
                end
            end
            K_REDIR, K_INDIS, K_DRIVE, K_CCS, K_CCDE, K_PFOE_LO, K_PFOE_HI: begin
                x_rdata = r_wr ? 8'h00 : misc_rdata;
                x_err   = misc_err;
            end
            K_ERR:   x_err = 1'b1;
            default: x_err = 1'b0;
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            o_rdata        <= x_rdata;
            o_changed_mask <= x_chg;
            o_port_levels  <= x_lev;
            o_guest_error  <= x_err;
        end
    end

    // ---------------- assertions ----------------
`include "gpio_port_register_block_unit_assert.svh"

    `GPR_ASSERT_NXT(a_accept_busy, start && !busy, busy, "command transfer did not raise busy")
    `GPR_ASSERT_NXT(a_exec_result, busy, o_valid && !busy, "no result one cycle after busy")
    `GPR_ASSERT_IMP(a_valid_idle, o_valid, !busy, "result strobe while busy")
    `GPR_ASSERT_IMP(a_chg_no_read, o_valid && o_changed_mask != 8'h00, o_rdata == 8'h00,
        "toggle mask reported with read data")

endmodule
